// File: rtl/assert_macros.svh
// Assertion macros shared by the indentation tracker RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define OIDG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another one on the next clock edge.
`define OIDG_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error(msg);

`endif

// File: rtl/oidg_pkg.sv
// Shared types and codes for the offside-rule indentation tracker.
// No dependencies; used by the interfaces and every RTL module.
package oidg_pkg;

  // Event codes of an input request
  typedef enum logic [1:0] {
    FUNC_OPEN  = 2'd0,
    FUNC_BREAK = 2'd1,
    FUNC_EOF   = 2'd2,
    FUNC_UNDEF = 2'd3
  } func_e;

  // Token codes of a result
  typedef enum logic [2:0] {
    KIND_OPEN     = 3'd0,
    KIND_CLOSE    = 3'd1,
    KIND_NEWLINE  = 3'd2,
    KIND_KEEP     = 3'd3,
    KIND_NONE     = 3'd4,
    KIND_SHALLOW  = 3'd5,
    KIND_OFFSIDES = 3'd6,
    KIND_OVERFLOW = 3'd7
  } kind_e;

  // Stack operation from the sequencer
  typedef struct packed {
    logic push;
    logic pop;
  } stack_cmd_t;

endpackage

// File: rtl/oidg_in_if.sv
// Input channel of the indentation tracker: valid/ready plus the event fields.
// Depends on oidg_pkg for the event code type.
interface oidg_in_if #(
  parameter int COLUMN_BITS = 10
);
  logic                   valid;
  logic                   ready;
  oidg_pkg::func_e        func;
  logic [COLUMN_BITS-1:0] depth;
  logic                   next_is_close;

  modport source (output valid, func, depth, next_is_close, input ready);
  modport sink   (input valid, func, depth, next_is_close, output ready);
endinterface

// File: rtl/oidg_out_if.sv
// Output channel of the indentation tracker: valid/ready plus the token fields.
// Depends on oidg_pkg for the token code type.
interface oidg_out_if;
  logic            valid;
  logic            ready;
  oidg_pkg::kind_e kind;
  logic            last;

  modport source (output valid, kind, last, input ready);
  modport sink   (input valid, kind, last, output ready);
endinterface

// File: rtl/oidg_stack.sv
// Depth stack: top entry in a register, deeper entries in a memory with a
// registered prefetch of the entry below the top. Depends on oidg_pkg.
`include "assert_macros.svh"

module oidg_stack #(
  parameter int STACK_DEPTH = 32,
  parameter int COLUMN_BITS = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  oidg_pkg::stack_cmd_t               cmd_i,
  input  logic [COLUMN_BITS-1:0]             push_depth_i,
  output logic [COLUMN_BITS-1:0]             top_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0]   cnt_o
);
  import oidg_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [COLUMN_BITS-1:0] mem [STACK_DEPTH];
  logic [COLUMN_BITS-1:0] top_q, top_d;
  logic [COLUMN_BITS-1:0] below_q;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [CW-1:0]          cnt_m1, cnt_d_m2;
  logic [AW-1:0]          waddr, raddr;
  logic                   wr_en, rd_en;

  // Next top and count
  always_comb begin
    top_d = top_q;
    cnt_d = cnt_q;
    if (cmd_i.push) begin
      top_d = push_depth_i;
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.pop) begin
      top_d = (cnt_q > CW'(1)) ? below_q : '0;
      cnt_d = cnt_q - CW'(1);
    end
  end

  // Spill the old top on push, prefetch the entry under the next top
  assign cnt_m1   = cnt_q - CW'(1);
  assign cnt_d_m2 = cnt_d - CW'(2);
  assign waddr    = cnt_m1[AW-1:0];
  assign raddr    = cnt_d_m2[AW-1:0];
  assign wr_en    = cmd_i.push && (cnt_q != '0);
  assign rd_en    = cnt_d > CW'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= top_q;
    end
    if (rd_en) begin
      below_q <= (wr_en && (waddr == raddr)) ? top_q : mem[raddr];
    end
  end

  // Hold top and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
      cnt_q <= '0;
    end else begin
      top_q <= top_d;
      cnt_q <= cnt_d;
    end
  end

  assign top_o = top_q;
  assign cnt_o = cnt_q;

  `OIDG_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(STACK_DEPTH), "stack count beyond depth")
  `OIDG_ASSERT(a_no_push_pop, clk_i, rst_ni, !(cmd_i.push && cmd_i.pop), "push and pop together")
  `OIDG_ASSERT(a_pop_filled, clk_i, rst_ni, !cmd_i.pop || (cnt_q != '0), "pop on empty stack")

endmodule

// File: rtl/oidg_seq.sv
// Sequencer of the indentation tracker: one depth comparator reused each cycle,
// pop loop, close-token counter and output register. Depends on oidg_pkg.
`include "assert_macros.svh"

module oidg_seq #(
  parameter int STACK_DEPTH = 32,
  parameter int COLUMN_BITS = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  oidg_in_if.sink                            req_i,
  oidg_out_if.source                         rsp_o,
  input  logic [COLUMN_BITS-1:0]             top_i,
  input  logic [$clog2(STACK_DEPTH+1)-1:0]   cnt_i,
  output oidg_pkg::stack_cmd_t               cmd_o,
  output logic [COLUMN_BITS-1:0]             push_depth_o
);
  import oidg_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_POP   = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  func_e                  func_q, func_d;
  logic [COLUMN_BITS-1:0] d_q, d_d;
  logic                   nc_q, nc_d;
  logic                   popped_q, popped_d;
  logic [CW-1:0]          pend_q, pend_d;
  logic                   fin_v_q, fin_v_d;
  kind_e                  fin_kind_q, fin_kind_d;
  logic                   out_valid_q, out_valid_d;
  kind_e                  out_kind_q, out_kind_d;
  logic                   out_last_q, out_last_d;

  logic  accept, can_emit, d_gt, d_lt;
  logic  dec_done, dec_v;
  kind_e dec_kind;
  logic  emit, emit_last, emit_close;
  kind_e emit_kind;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign can_emit    = !out_valid_q || rsp_o.ready;

  // Shared depth comparator
  assign d_gt = d_q > top_i;
  assign d_lt = d_q < top_i;

  // Push the held opener depth
  assign push_depth_o = d_q;

  // Decide one step of the current request
  always_comb begin
    dec_done = 1'b0;
    dec_v    = 1'b0;
    dec_kind = KIND_NONE;
    cmd_o    = '0;
    if (state_q == ST_POP) begin
      case (func_q)
        FUNC_OPEN: begin
          dec_done = 1'b1;
          dec_v    = 1'b1;
          if (!d_gt) begin
            dec_kind = KIND_SHALLOW;
          end else if (cnt_i < CW'(STACK_DEPTH)) begin
            dec_kind   = KIND_OPEN;
            cmd_o.push = 1'b1;
          end else begin
            dec_kind = KIND_OVERFLOW;
          end
        end
        FUNC_BREAK: begin
          if (d_gt) begin
            dec_done = 1'b1;
            dec_v    = 1'b1;
            dec_kind = popped_q ? KIND_OFFSIDES : KIND_KEEP;
          end else if (d_lt) begin
            cmd_o.pop = 1'b1;
          end else begin
            dec_done = 1'b1;
            dec_v    = !nc_q || !popped_q;
            dec_kind = nc_q ? KIND_NONE : KIND_NEWLINE;
          end
        end
        FUNC_EOF: begin
          if (cnt_i != '0) begin
            cmd_o.pop = 1'b1;
          end else begin
            dec_done = 1'b1;
            dec_v    = !popped_q;
            dec_kind = KIND_NONE;
          end
        end
        default: begin
          dec_done = 1'b1;
          dec_v    = 1'b1;
          dec_kind = KIND_NONE;
        end
      endcase
    end
  end

  // Sequence the request and pick at most one result per cycle
  always_comb begin
    state_d    = state_q;
    func_d     = func_q;
    d_d        = d_q;
    nc_d       = nc_q;
    popped_d   = popped_q;
    fin_v_d    = fin_v_q;
    fin_kind_d = fin_kind_q;
    emit       = 1'b0;
    emit_last  = 1'b0;
    emit_close = 1'b0;
    emit_kind  = KIND_NONE;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          func_d   = req_i.func;
          d_d      = req_i.depth;
          nc_d     = req_i.next_is_close;
          popped_d = 1'b0;
          fin_v_d  = 1'b0;
          state_d  = ST_POP;
        end
      end
      ST_POP: begin
        popped_d = popped_q || cmd_o.pop;
        if (can_emit && (pend_q > CW'(1))) begin
          emit       = 1'b1;
          emit_close = 1'b1;
          emit_kind  = KIND_CLOSE;
        end else if (can_emit && dec_done && dec_v && (pend_q == '0)) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          emit_kind = dec_kind;
          state_d   = ST_IDLE;
        end
        if (dec_done && !emit_last) begin
          fin_v_d    = dec_v;
          fin_kind_d = dec_kind;
          state_d    = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (can_emit) begin
          emit = 1'b1;
          if (pend_q != '0) begin
            emit_close = 1'b1;
            emit_kind  = KIND_CLOSE;
            emit_last  = (pend_q == CW'(1)) && !fin_v_q;
          end else begin
            emit_kind = fin_kind_q;
            emit_last = 1'b1;
          end
          if (emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Track closes popped but not yet sent
  always_comb begin
    pend_d = pend_q;
    if (state_q == ST_IDLE) begin
      pend_d = '0;
    end else begin
      pend_d = pend_q + CW'(cmd_o.pop) - CW'(emit_close);
    end
  end

  // Load or drain the output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_kind_d  = emit_kind;
      out_last_d  = emit_last;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    d_q        <= d_d;
    nc_q       <= nc_d;
    popped_q   <= popped_d;
    fin_v_q    <= fin_v_d;
    fin_kind_q <= fin_kind_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.kind  = out_kind_q;
  assign rsp_o.last  = out_last_q;

  `OIDG_ASSERT(a_pop_nonempty, clk_i, rst_ni,
               !cmd_o.pop || (cnt_i != '0), "pop on empty stack")
  `OIDG_ASSERT(a_push_room, clk_i, rst_ni,
               !cmd_o.push || (cnt_i != CW'(STACK_DEPTH)), "push on full stack")
  `OIDG_ASSERT_NEXT(a_last_idle, clk_i, rst_ni,
                    emit && emit_last, state_q == ST_IDLE, "not idle after last result")
  `OIDG_ASSERT(a_emit_slot, clk_i, rst_ni,
               !emit || can_emit, "result overwrites unsent result")

endmodule

// File: rtl/offside_indent_dedent_generator_top.sv
// Top level of the offside-rule indentation tracker.
// Depends on oidg_pkg, oidg_in_if, oidg_out_if, oidg_stack and oidg_seq.
//
// Usage:
//   req_i carries one event per request: func (opener, line break, end of
//   file), depth (opener depth or leading space count) and next_is_close.
//   rsp_o returns the tokens caused by it, one per transfer, with last set on
//   the final one. Both channels use valid/ready.
// Sequencing:
//   The block takes one request at a time; ready is high only between
//   requests. After a request is accepted, the sequencer runs one
//   compare-and-pop step per cycle through the single depth comparator,
//   then one final compare, then sends the remaining tokens. Each result
//   is registered in the output register before it reaches rsp_o.
// Reset:
//   rst_ni clears the stack count (all levels closed) and the sequencer.
//   The stack memory needs no clearing pass.
// Stalls:
//   Results sit in an output register; while rsp_o.ready is low pops go on
//   but tokens wait, and a new request may be taken once the last result
//   is in that register.
module offside_indent_dedent_generator_top #(
  parameter int STACK_DEPTH = 32,
  parameter int COLUMN_BITS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  oidg_in_if.sink    req_i,
  oidg_out_if.source rsp_o
);
  import oidg_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);

  stack_cmd_t             cmd;
  logic [COLUMN_BITS-1:0] top;
  logic [COLUMN_BITS-1:0] push_depth;
  logic [CW-1:0]          cnt;

  // Sequencer with the shared comparator
  oidg_seq #(
    .STACK_DEPTH (STACK_DEPTH),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .rsp_o        (rsp_o),
    .top_i        (top),
    .cnt_i        (cnt),
    .cmd_o        (cmd),
    .push_depth_o (push_depth)
  );

  // Depth stack
  oidg_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_stack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .push_depth_i (push_depth),
    .top_o        (top),
    .cnt_o        (cnt)
  );

endmodule

// File: tb/sv/oidg_token_checker.sv
`timescale 1ns / 1ps
// Token checker for the indentation tracker: watches both channels, predicts the
// tokens of every accepted request and compares them with the returned ones.
// Depends on oidg_pkg for the event and token codes.
module oidg_token_checker #(
  parameter int STACK_DEPTH = 32,
  parameter int COLUMN_BITS = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  input  logic                   req_ready_i,
  input  oidg_pkg::func_e        req_func_i,
  input  logic [COLUMN_BITS-1:0] req_depth_i,
  input  logic                   req_next_is_close_i,
  input  logic                   rsp_valid_i,
  input  logic                   rsp_ready_i,
  input  oidg_pkg::kind_e        rsp_kind_i,
  input  logic                   rsp_last_i,
  output int                     tokens_due_o,
  output int                     errors_o
);
  import oidg_pkg::*;

  typedef struct packed {
    kind_e kind;
    logic  last;
  } token_t;

  // Own copy of the open block depths
  logic [COLUMN_BITS-1:0] level_mem [STACK_DEPTH];
  int                     open_levels = 0;
  token_t                 pending_tokens [$];
  token_t                 want;
  int                     mismatch_count = 0;

  function automatic logic [COLUMN_BITS-1:0] top_level();
    return (open_levels == 0) ? '0 : level_mem[open_levels-1];
  endfunction

  // Work out the tokens of one request and append them, last flag on the final one
  function automatic void predict_tokens(func_e func, logic [COLUMN_BITS-1:0] depth,
                                         logic next_close);
    kind_e seq [$];
    case (func)
      FUNC_OPEN: begin
        if (depth > top_level()) begin
          if (open_levels < STACK_DEPTH) begin
            level_mem[open_levels] = depth;
            open_levels++;
            seq.push_back(KIND_OPEN);
          end else begin
            seq.push_back(KIND_OVERFLOW);
          end
        end else begin
          seq.push_back(KIND_SHALLOW);
        end
      end
      FUNC_BREAK: begin
        if (depth > top_level()) begin
          seq.push_back(KIND_KEEP);
        end else begin
          // pop every level deeper than the leading space count
          while (depth < top_level()) begin
            open_levels--;
            seq.push_back(KIND_CLOSE);
          end
          if (depth == top_level()) begin
            if (!next_close) seq.push_back(KIND_NEWLINE);
            else if (seq.size() == 0) seq.push_back(KIND_NONE);
          end else begin
            seq.push_back(KIND_OFFSIDES);
          end
        end
      end
      FUNC_EOF: begin
        while (open_levels > 0) begin
          open_levels--;
          seq.push_back(KIND_CLOSE);
        end
        if (seq.size() == 0) seq.push_back(KIND_NONE);
      end
      default: seq.push_back(KIND_NONE);
    endcase
    foreach (seq[i]) pending_tokens.push_back('{kind: seq[i], last: (i == seq.size() - 1)});
  endfunction

  // Compare returned tokens first, then predict for a request taken on the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (pending_tokens.size() == 0) begin
          $error("token: none expected, got kind %0d last %0b", rsp_kind_i, rsp_last_i);
          mismatch_count++;
        end else begin
          want = pending_tokens.pop_front();
          if (rsp_kind_i !== want.kind) begin
            $error("kind: expected %0d (%s), got %0d", want.kind, want.kind.name(),
                   rsp_kind_i);
            mismatch_count++;
          end
          if (rsp_last_i !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, rsp_last_i);
            mismatch_count++;
          end
        end
      end
      if (req_valid_i && req_ready_i)
        predict_tokens(req_func_i, req_depth_i, req_next_is_close_i);
    end
    tokens_due_o <= pending_tokens.size();
    errors_o     <= mismatch_count;
  end

endmodule

// File: tb/sv/tb_offside_indent_dedent_generator_top.sv
`timescale 1ns / 1ps
// Testbench top for the indentation tracker: clock, reset, event stimulus and
// token throttling. Depends on oidg_pkg, both channel interfaces, the tracker top and oidg_token_checker.
module tb_offside_indent_dedent_generator_top;
  import oidg_pkg::*;

  localparam int STACK_DEPTH = 32;
  localparam int COLUMN_BITS = 10;
  localparam int MAX_DEPTH   = (1 << COLUMN_BITS) - 1;
  localparam int RANDOM_EVENTS = 350;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   tokens_due;
  int   token_errors;
  int   sent_events = 0;
  // Stimulus-side view of the open depths, used only to aim the events
  int unsigned shadow_q [$];

  oidg_in_if #(.COLUMN_BITS(COLUMN_BITS)) req_if ();
  oidg_out_if rsp_if ();

  offside_indent_dedent_generator_top #(
    .STACK_DEPTH(STACK_DEPTH),
    .COLUMN_BITS(COLUMN_BITS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  oidg_token_checker #(
    .STACK_DEPTH(STACK_DEPTH),
    .COLUMN_BITS(COLUMN_BITS)
  ) u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .req_valid_i        (req_if.valid),
    .req_ready_i        (req_if.ready),
    .req_func_i         (req_if.func),
    .req_depth_i        (req_if.depth),
    .req_next_is_close_i(req_if.next_is_close),
    .rsp_valid_i        (rsp_if.valid),
    .rsp_ready_i        (rsp_if.ready),
    .rsp_kind_i         (rsp_if.kind),
    .rsp_last_i         (rsp_if.last),
    .tokens_due_o       (tokens_due),
    .errors_o           (token_errors)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly no idling, some short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic int unsigned pick_step();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
  endfunction

  function automatic int unsigned shadow_top();
    return (shadow_q.size() == 0) ? 0 : shadow_q[shadow_q.size()-1];
  endfunction

  function automatic int unsigned clip_depth(int unsigned d);
    return (d > MAX_DEPTH) ? MAX_DEPTH : d;
  endfunction

  // Offer one event, hold it until taken, then idle for a random gap
  task automatic send_event(func_e func, int unsigned depth, bit next_close);
    int gap;
    gap = pick_gap();
    req_if.valid         <= 1'b1;
    req_if.func          <= func;
    req_if.depth         <= depth[COLUMN_BITS-1:0];
    req_if.next_is_close <= next_close;
    do @(posedge clk_i); while (!req_if.ready);
    sent_events++;
    case (func)
      FUNC_OPEN:
        if (depth > shadow_top() && shadow_q.size() < STACK_DEPTH) shadow_q.push_back(depth);
      FUNC_BREAK:
        if (depth <= shadow_top())
          while (depth < shadow_top()) void'(shadow_q.pop_back());
      FUNC_EOF: shadow_q.delete();
      default: ;
    endcase
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold off new requests until every predicted token has come back
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (tokens_due != 0);
  endtask

  // Program-like lines: openers (some shallow), breaks at open levels, inline space, offsides, end of file
  task automatic block_episode();
    int          lines;
    int          roll;
    int          idx;
    int unsigned top;
    int unsigned lower;
    int unsigned upper;
    lines = $urandom_range(4, 16);
    repeat (lines) begin
      roll = $urandom_range(0, 99);
      top  = shadow_top();
      if (roll < 30) begin
        send_event(FUNC_OPEN, clip_depth(top + pick_step()), bit'($urandom_range(0, 1)));
      end else if (roll < 65) begin
        idx = $urandom_range(0, shadow_q.size());
        send_event(FUNC_BREAK, (idx == shadow_q.size()) ? 0 : shadow_q[idx],
                   bit'($urandom_range(0, 1)));
      end else if (roll < 75) begin
        send_event(FUNC_BREAK, clip_depth(top + pick_step()), bit'($urandom_range(0, 1)));
      end else if (roll < 85 && shadow_q.size() > 0) begin
        // aim between two open levels where there is room
        idx   = $urandom_range(0, shadow_q.size() - 1);
        lower = (idx == 0) ? 0 : shadow_q[idx-1];
        upper = shadow_q[idx];
        send_event(FUNC_BREAK,
                   (upper - lower >= 2) ? $urandom_range(lower + 1, upper - 1) : lower,
                   bit'($urandom_range(0, 1)));
      end else if (roll < 92) begin
        send_event(FUNC_OPEN, $urandom_range(0, top), bit'($urandom_range(0, 1)));
      end else begin
        send_event(FUNC_EOF, $urandom_range(0, MAX_DEPTH), bit'($urandom_range(0, 1)));
      end
    end
  endtask

  // Nest past the stack limit, dedent part way, close everything
  task automatic deep_episode();
    int unsigned d;
    d = 0;
    send_event(FUNC_EOF, 0, 1'b0);
    repeat (STACK_DEPTH + $urandom_range(1, 3)) begin
      d = d + $urandom_range(1, 28);
      send_event(FUNC_OPEN, d, bit'($urandom_range(0, 1)));
    end
    send_event(FUNC_BREAK, shadow_q[$urandom_range(0, shadow_q.size() - 1)],
               bit'($urandom_range(0, 1)));
    block_episode();
    send_event(FUNC_EOF, $urandom_range(0, MAX_DEPTH), 1'b0);
    wait_drained();
  endtask

  // Arbitrary events, the undefined code among them
  task automatic noise_episode();
    repeat ($urandom_range(3, 8))
      send_event(func_e'($urandom_range(0, 3)), $urandom_range(0, MAX_DEPTH),
                 bit'($urandom_range(0, 1)));
  endtask

  // Throttle the token side: ready bursts of random length, gaps between them
  initial begin : rsp_throttle
    int run;
    int hold;
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      run  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
      hold = pick_gap();
      rsp_if.ready <= 1'b1;
      repeat (run) @(posedge clk_i);
      if (hold > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    int roll;
    int first_random;
    rst_ni               <= 1'b0;
    req_if.valid         <= 1'b0;
    req_if.func          <= FUNC_OPEN;
    req_if.depth         <= '0;
    req_if.next_is_close <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty stack cases and the undefined code
    send_event(FUNC_BREAK, 0, 1'b0);
    send_event(FUNC_BREAK, 0, 1'b1);
    send_event(FUNC_EOF, 0, 1'b0);
    send_event(FUNC_UNDEF, MAX_DEPTH, 1'b1);
    // Shallow openers and the deepest column
    send_event(FUNC_OPEN, 0, 1'b0);
    send_event(FUNC_OPEN, 4, 1'b0);
    send_event(FUNC_OPEN, 4, 1'b1);
    send_event(FUNC_OPEN, MAX_DEPTH, 1'b0);
    send_event(FUNC_BREAK, MAX_DEPTH, 1'b0);
    send_event(FUNC_BREAK, MAX_DEPTH, 1'b1);
    // Offsides after two pops
    send_event(FUNC_BREAK, 2, 1'b0);
    // Inline space, then a dedent whose newline is suppressed
    send_event(FUNC_OPEN, 8, 1'b0);
    send_event(FUNC_OPEN, 16, 1'b0);
    send_event(FUNC_BREAK, 20, 1'b0);
    send_event(FUNC_BREAK, 8, 1'b1);
    send_event(FUNC_BREAK, 8, 1'b0);
    send_event(FUNC_EOF, MAX_DEPTH, 1'b1);
    send_event(FUNC_OPEN, 1, 1'b0);
    send_event(FUNC_BREAK, 0, 1'b0);
    send_event(FUNC_EOF, 0, 1'b0);
    wait_drained();

    // Random part: a full stack first, then mostly well-formed blocks
    first_random = sent_events;
    deep_episode();
    while (sent_events < first_random + RANDOM_EVENTS) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) deep_episode();
      else if (roll < 78) block_episode();
      else noise_episode();
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (token_errors == 0 && tokens_due == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(20_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule
